>>> hw/rtl/fce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fce_pkg;

    localparam int CLU_W      = 28;
    localparam int FAT_W      = 32;
    localparam int SIZE_W     = 32;
    localparam int CBYTES_W   = 17;
    localparam int BYTES_W    = 45;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [CLU_W-1:0]   FAT_FREE     = 28'h0000000;
    localparam logic [CLU_W-1:0]   FAT_RESERVED = 28'h0000001;
    localparam logic [CLU_W-1:0]   FAT_BAD      = 28'hFFFFFF7;
    localparam logic [CLU_W-1:0]   FAT_EOC_MIN  = 28'hFFFFFF8;
    localparam logic [CLU_W-1:0]   MAX28        = 28'hFFFFFFF;
    localparam logic [BYTES_W-1:0] MAX45        = {BYTES_W{1'b1}};

    localparam logic [STATUS_W-1:0] ST_CONTINUE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FINAL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_CLUSTER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_BYTES = 2'd2;

    localparam logic [CLU_W-1:0]    RST_HEAD_CLUSTER  = 28'd2;
    localparam logic [SIZE_W-1:0]   RST_FILE_SIZE     = 32'd0;
    localparam logic [CBYTES_W-1:0] RST_CLUSTER_BYTES = 17'd4096;

    typedef enum logic [1:0] {
        KIND_LINK,
        KIND_EOC,
        KIND_BAD
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [CLU_W-1:0] value;
    } q_entry_t;

    typedef struct packed {
        logic [CLU_W-1:0]    head_cluster;
        logic [SIZE_W-1:0]   file_size_bytes;
        logic [CBYTES_W-1:0] cluster_bytes;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/fce_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fce_in_if;
    import fce_pkg::*;

    logic             valid;
    logic             ready;
    logic [FAT_W-1:0] fat_value;

    modport source (output valid, output fat_value, input ready);
    modport sink   (input valid, input fat_value, output ready);
endinterface

interface fce_out_if;
    import fce_pkg::*;

    logic                valid;
    logic                ready;
    logic [CLU_W-1:0]    extent_file_offset;
    logic [CLU_W-1:0]    extent_start_cluster;
    logic [CLU_W-1:0]    extent_index;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output extent_file_offset, output extent_start_cluster,
                    output extent_index, output status, output last, input ready);
    modport sink   (input valid, input extent_file_offset, input extent_start_cluster,
                    input extent_index, input status, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fce_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fce_front (
    fce_in_if.sink              in_ch,
    output logic                push_valid,
    output fce_pkg::q_entry_t   push_entry,
    input  logic                push_ready
);
    import fce_pkg::*;

    logic [CLU_W-1:0] v28;

    // only the low 28 bits of an entry carry meaning
    assign v28 = in_ch.fat_value[CLU_W-1:0];

    always_comb
    begin
        push_entry.value = v28;
        if (v28 == FAT_FREE || v28 == FAT_RESERVED || v28 == FAT_BAD)
        begin
            push_entry.kind = KIND_BAD;
        end
        else if (v28 >= FAT_EOC_MIN)
        begin
            push_entry.kind = KIND_EOC;
        end
        else
        begin
            push_entry.kind = KIND_LINK;
        end
    end

    assign push_valid  = in_ch.valid;
    assign in_ch.ready = push_ready;

endmodule

`default_nettype wire

>>> hw/rtl/fce_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fce_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  fce_pkg::q_entry_t   push_entry,
    output logic                push_ready,
    output logic                pop_valid,
    output fce_pkg::q_entry_t   pop_entry,
    input  logic                pop
);
    import fce_pkg::*;

    q_entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/fce_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fce_back (
    input  logic                clk,
    input  logic                rst_n,
    input  fce_pkg::cfg_t       cfg,
    input  logic                pop_valid,
    input  fce_pkg::q_entry_t   pop_entry,
    output logic                pop,
    fce_out_if.source           out_ch
);
    import fce_pkg::*;

    logic                in_chain_reg;
    logic                in_chain_next;
    logic [CLU_W-1:0]    cur_reg;
    logic [CLU_W-1:0]    cur_next;
    logic [CLU_W-1:0]    seen_reg;
    logic [CLU_W-1:0]    seen_next;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [BYTES_W-1:0]  bytes_next;
    logic [CLU_W-1:0]    run_off_reg;
    logic [CLU_W-1:0]    run_off_next;
    logic [CLU_W-1:0]    run_clu_reg;
    logic [CLU_W-1:0]    run_clu_next;
    logic [CLU_W-1:0]    ext_reg;
    logic [CLU_W-1:0]    ext_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CLU_W-1:0]    out_off_reg;
    logic [CLU_W-1:0]    out_off_next;
    logic [CLU_W-1:0]    out_clu_reg;
    logic [CLU_W-1:0]    out_clu_next;
    logic [CLU_W-1:0]    out_idx_reg;
    logic [CLU_W-1:0]    out_idx_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic                out_last_reg;
    logic                out_last_next;

    // state as seen by this item, a new chain starts from the config
    logic [CLU_W-1:0]    cur_eff;
    logic [CLU_W-1:0]    seen_eff;
    logic [BYTES_W-1:0]  bytes_eff;
    logic [CLU_W-1:0]    run_off_eff;
    logic [CLU_W-1:0]    run_clu_eff;
    logic [CLU_W-1:0]    ext_eff;

    logic                fire;
    logic                contiguous;
    logic [BYTES_W:0]    bytes_sum;
    logic [CLU_W-1:0]    seen_inc;
    logic [BYTES_W-1:0]  bytes_inc;
    logic [CLU_W-1:0]    ext_inc;

    assign fire = pop_valid && (!out_valid_reg || out_ch.ready);
    assign pop  = fire;

    assign cur_eff     = in_chain_reg ? cur_reg     : cfg.head_cluster;
    assign seen_eff    = in_chain_reg ? seen_reg    : CLU_W'(1);
    assign bytes_eff   = in_chain_reg ? bytes_reg   : BYTES_W'(cfg.cluster_bytes);
    assign run_off_eff = in_chain_reg ? run_off_reg : '0;
    assign run_clu_eff = in_chain_reg ? run_clu_reg : cfg.head_cluster;
    assign ext_eff     = in_chain_reg ? ext_reg     : '0;

    assign contiguous = ({1'b0, pop_entry.value} == ({1'b0, cur_eff} + 1'b1));
    assign bytes_sum  = {1'b0, bytes_eff} + (BYTES_W + 1)'(cfg.cluster_bytes);
    assign bytes_inc  = bytes_sum[BYTES_W] ? MAX45 : bytes_sum[BYTES_W-1:0];
    assign seen_inc   = (seen_eff == MAX28) ? seen_eff : seen_eff + 1'b1;
    assign ext_inc    = (ext_eff == MAX28) ? ext_eff : ext_eff + 1'b1;

    always_comb
    begin
        in_chain_next   = in_chain_reg;
        cur_next        = cur_reg;
        seen_next       = seen_reg;
        bytes_next      = bytes_reg;
        run_off_next    = run_off_reg;
        run_clu_next    = run_clu_reg;
        ext_next        = ext_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_off_next    = out_off_reg;
        out_clu_next    = out_clu_reg;
        out_idx_next    = out_idx_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        if (fire)
        begin
            unique case (pop_entry.kind)
                KIND_BAD:
                begin
                    in_chain_next   = 1'b0;
                    out_valid_next  = 1'b1;
                    out_off_next    = '0;
                    out_clu_next    = '0;
                    out_idx_next    = '0;
                    out_status_next = ST_BAD;
                    out_last_next   = 1'b1;
                end
                KIND_EOC:
                begin
                    in_chain_next  = 1'b0;
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (bytes_eff < BYTES_W'(cfg.file_size_bytes))
                    begin
                        out_off_next    = '0;
                        out_clu_next    = '0;
                        out_idx_next    = '0;
                        out_status_next = ST_SHORT;
                    end
                    else
                    begin
                        out_off_next    = run_off_eff;
                        out_clu_next    = run_clu_eff;
                        out_idx_next    = ext_eff;
                        out_status_next = ST_FINAL;
                    end
                end
                KIND_LINK:
                begin
                    in_chain_next = 1'b1;
                    cur_next      = pop_entry.value;
                    seen_next     = seen_inc;
                    bytes_next    = bytes_inc;
                    if (contiguous)
                    begin
                        run_off_next = run_off_eff;
                        run_clu_next = run_clu_eff;
                        ext_next     = ext_eff;
                    end
                    else
                    begin
                        // chain jumps: close the run, new one starts at the current count
                        out_valid_next  = 1'b1;
                        out_off_next    = run_off_eff;
                        out_clu_next    = run_clu_eff;
                        out_idx_next    = ext_eff;
                        out_status_next = ST_CONTINUE;
                        out_last_next   = 1'b0;
                        ext_next        = ext_inc;
                        run_off_next    = seen_eff;
                        run_clu_next    = pop_entry.value;
                    end
                end
                default:
                begin
                    in_chain_next = in_chain_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_chain_reg  <= 1'b0;
            cur_reg       <= '0;
            seen_reg      <= '0;
            bytes_reg     <= '0;
            run_off_reg   <= '0;
            run_clu_reg   <= '0;
            ext_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_chain_reg  <= in_chain_next;
            cur_reg       <= cur_next;
            seen_reg      <= seen_next;
            bytes_reg     <= bytes_next;
            run_off_reg   <= run_off_next;
            run_clu_reg   <= run_clu_next;
            ext_reg       <= ext_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_off_reg    <= out_off_next;
        out_clu_reg    <= out_clu_next;
        out_idx_reg    <= out_idx_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign out_ch.valid                = out_valid_reg;
    assign out_ch.extent_file_offset   = out_off_reg;
    assign out_ch.extent_start_cluster = out_clu_reg;
    assign out_ch.extent_index         = out_idx_reg;
    assign out_ch.status               = out_status_reg;
    assign out_ch.last                 = out_last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fat32_chain_extent_builder.sv
// FAT32 cluster chain to extent list.
// in_ch carries one FAT entry per item: the entry of the cluster the chain is on,
// starting with the entry of the head cluster register. out_ch gives zero or one
// item per input: an extent when the chain jumps, the final extent or an error at
// the end of chain (last high). After a result with last high the next input is
// again the entry of the head cluster.
// Config is written through cfg_we / cfg_index / cfg_wdata, which the user must
// do only while the block is idle; the block itself does not enforce this.
// Throughput: one item per cycle unless out_ch stalls; the back end updates its
// running counters (one 45-bit add and compare) per item. Each accepted item
// passes the queue, then the back end registers its result for out_ch.
// Reset clears the queue, the output valid flag and the chain state; the config
// registers return to head cluster 2, file size 0 bytes, cluster size 4096 bytes.
// When out_ch stalls the output register holds its item, the back end stops and
// the queue fills; in_ch.ready drops once the queue holds two items.
`timescale 1ns / 1ps
`default_nettype none

module fat32_chain_extent_builder (
    input  logic                              clk,
    input  logic                              rst_n,
    fce_in_if.sink                            in_ch,
    fce_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [fce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fce_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import fce_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     push_valid;
    logic     push_ready;
    q_entry_t push_entry;
    logic     pop_valid;
    logic     pop;
    q_entry_t pop_entry;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAD_CLUSTER:  cfg_next.head_cluster    = cfg_wdata[CLU_W-1:0];
                CFG_FILE_SIZE:     cfg_next.file_size_bytes = cfg_wdata[SIZE_W-1:0];
                CFG_CLUSTER_BYTES: cfg_next.cluster_bytes   = cfg_wdata[CBYTES_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_cluster    <= RST_HEAD_CLUSTER;
            cfg_reg.file_size_bytes <= RST_FILE_SIZE;
            cfg_reg.cluster_bytes   <= RST_CLUSTER_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fce_front u_front (
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    fce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop)
    );

    fce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire
